// ===== hdl/dual_spi_sram_burst_sequencer_assert.svh =====
// Assertion macros shared by the burst sequencer RTL.
`ifndef DUAL_SPI_SRAM_BURST_SEQUENCER_ASSERT_SVH
`define DUAL_SPI_SRAM_BURST_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSSBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSSBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dssbs_pkg.sv =====
// Types, codes and constants of the dual serial SRAM burst sequencer.
`timescale 1ns / 1ps
package dssbs_pkg;

  localparam int DEF_DEVICE_WORDS  = 65536;
  localparam int DEF_ADDRESS_BYTES = 3;

  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] FILLER    = 8'h7E;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WRITE = 2'd1,
    PH_READ  = 2'd2,
    PH_DUMMY = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REQ_WR_START = 2'd0,
    REQ_RD_START = 2'd1,
    REQ_WR_DATA  = 2'd2,
    REQ_RX_BYTE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_WORD    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef struct packed {
    req_t        req_type;
    logic [17:0] word_addr;
    logic [17:0] word_count;
    logic [15:0] write_word;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic        device_select;
    logic        read_clock_mode;
    logic [15:0] read_word;
  } result_t;

  function automatic result_t mk_res(input kind_t k, input logic [7:0] tx, input logic dev,
                                     input logic mode, input logic [15:0] word);
    result_t r;
    r.kind            = k;
    r.tx_byte         = tx;
    r.device_select   = dev;
    r.read_clock_mode = mode;
    r.read_word       = word;
    return r;
  endfunction

endpackage

// ===== hdl/dssbs_core.sv =====
// Burst state and the per-transaction result list of the sequencer.
`timescale 1ns / 1ps
module dssbs_core
  import dssbs_pkg::*;
#(
  parameter int DEVICE_WORDS  = DEF_DEVICE_WORDS,
  parameter int ADDRESS_BYTES = DEF_ADDRESS_BYTES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load_i,
  input  logic                         wrap_en_i,
  input  item_t                        item_i,
  output result_t [ADDRESS_BYTES+3:0]  res_o,
  output logic [$clog2(ADDRESS_BYTES+5)-1:0] res_cnt_o
);

  `include "dual_spi_sram_burst_sequencer_assert.svh"

  localparam int MAXR    = ADDRESS_BYTES + 4;
  localparam int CNTW    = $clog2(MAXR + 1);
  localparam int IDXW    = $clog2(MAXR);
  localparam int HDR_LEN = ADDRESS_BYTES + 2;
  localparam int BAW     = 8 * ADDRESS_BYTES;
  localparam int SPW     = $clog2(2 * DEVICE_WORDS + 1);
  localparam int CW      = (SPW > 19) ? SPW : 19;
  localparam int SEGW    = (SPW < 18) ? SPW : 18;
  localparam logic [CW-1:0] SPACE_W = CW'(2 * DEVICE_WORDS);
  localparam logic [CW-1:0] SPACE_M = CW'(2 * DEVICE_WORDS - 1);
  localparam logic [CW-1:0] DEV_W   = CW'(DEVICE_WORDS);

  phase_t            phase_r, phase_nxt;
  logic              dev_r, dev_nxt;
  logic [SEGW-1:0]   seg_r, seg_nxt;
  logic [SEGW-1:0]   spill_r, spill_nxt;
  logic              upper_r, upper_nxt;
  logic [7:0]        low_r, low_nxt;

  function automatic result_t hdr_rec(input logic reading, input int k,
                                      input logic [BAW-1:0] ba, input logic dev);
    logic [BAW-1:0] sh;
    result_t        r;
    sh = ba >> (8 * (ADDRESS_BYTES - k));
    if (k == 0) begin
      r = mk_res(KIND_TX, reading ? CMD_READ : CMD_WRITE, dev, 1'b0, 16'h0);
    end else if (k <= ADDRESS_BYTES) begin
      r = mk_res(KIND_TX, sh[7:0], dev, 1'b0, 16'h0);
    end else begin
      r = mk_res(KIND_TX, FILLER, dev, 1'b0, 16'h0);
    end
    return r;
  endfunction

  always_comb begin
    phase_t          ph;
    logic            dev;
    logic [SEGW-1:0] seg;
    logic [SEGW-1:0] spill;
    logic            up;
    logic [7:0]      low;
    logic [CNTW-1:0] n;
    logic            reading;
    logic            do_end;
    logic [CW-1:0]   addr_w;
    logic [CW-1:0]   end_w;
    logic [CW-1:0]   loc;
    logic [BAW-1:0]  ba;
    ph      = phase_r;
    dev     = dev_r;
    seg     = seg_r;
    spill   = spill_r;
    up      = upper_r;
    low     = low_r;
    n       = '0;
    res_o   = '0;
    do_end  = 1'b0;
    reading = (item_i.req_type == REQ_RD_START);
    addr_w  = CW'(item_i.word_addr);
    if (wrap_en_i) begin
      addr_w = addr_w & SPACE_M;
    end
    end_w = addr_w + CW'(item_i.word_count);
    loc   = (addr_w >= DEV_W) ? addr_w - DEV_W : addr_w;
    ba    = BAW'({loc, 1'b0});

    unique case (item_i.req_type)
      REQ_WR_START, REQ_RD_START: begin
        if (ph != PH_IDLE) begin
          res_o[n[IDXW-1:0]] = mk_res(KIND_RELEASE, 8'h0, dev, 1'b0, 16'h0);
          n  = n + CNTW'(1);
          ph = PH_IDLE;
        end
        if (addr_w >= SPACE_W || end_w > SPACE_W) begin
          res_o[n[IDXW-1:0]] = mk_res(KIND_ERROR, 8'h0, 1'b0, 1'b0, 16'h0);
          n = n + CNTW'(1);
        end else begin
          dev = (addr_w >= DEV_W);
          if (!dev && end_w > DEV_W) begin
            seg   = SEGW'(DEV_W - addr_w);
            spill = SEGW'(end_w - DEV_W);
          end else begin
            seg   = SEGW'(item_i.word_count);
            spill = '0;
          end
          up  = 1'b0;
          low = 8'h0;
          for (int k = 0; k < HDR_LEN; k++) begin
            if (k <= ADDRESS_BYTES || reading) begin
              res_o[n[IDXW-1:0]] = hdr_rec(reading, k, ba, dev);
              n = n + CNTW'(1);
            end
          end
          ph     = reading ? PH_DUMMY : PH_WRITE;
          do_end = (seg == '0);
        end
      end
      REQ_WR_DATA: begin
        if (ph != PH_WRITE) begin
          res_o[n[IDXW-1:0]] = mk_res(KIND_ERROR, 8'h0, 1'b0, 1'b0, 16'h0);
          n = n + CNTW'(1);
        end else begin
          res_o[n[IDXW-1:0]] = mk_res(KIND_TX, item_i.write_word[7:0], dev, 1'b0, 16'h0);
          n = n + CNTW'(1);
          res_o[n[IDXW-1:0]] = mk_res(KIND_TX, item_i.write_word[15:8], dev, 1'b0, 16'h0);
          n      = n + CNTW'(1);
          seg    = seg - SEGW'(1);
          do_end = (seg == '0);
        end
      end
      REQ_RX_BYTE: begin
        if (ph == PH_DUMMY) begin
          ph = PH_READ;
          up = 1'b0;
          res_o[n[IDXW-1:0]] = mk_res(KIND_TX, FILLER, dev, 1'b1, 16'h0);
          n = n + CNTW'(1);
        end else if (ph != PH_READ) begin
          res_o[n[IDXW-1:0]] = mk_res(KIND_ERROR, 8'h0, 1'b0, 1'b0, 16'h0);
          n = n + CNTW'(1);
        end else if (!up) begin
          low = item_i.rx_byte;
          up  = 1'b1;
          res_o[n[IDXW-1:0]] = mk_res(KIND_TX, FILLER, dev, 1'b1, 16'h0);
          n = n + CNTW'(1);
        end else begin
          up = 1'b0;
          res_o[n[IDXW-1:0]] = mk_res(KIND_WORD, 8'h0, dev, 1'b0, {item_i.rx_byte, low});
          n   = n + CNTW'(1);
          seg = seg - SEGW'(1);
          if (seg == '0) begin
            do_end = 1'b1;
          end else begin
            res_o[n[IDXW-1:0]] = mk_res(KIND_TX, FILLER, dev, 1'b1, 16'h0);
            n = n + CNTW'(1);
          end
        end
      end
      default: begin
      end
    endcase

    if (do_end) begin
      reading = (ph == PH_READ || ph == PH_DUMMY);
      res_o[n[IDXW-1:0]] = mk_res(KIND_RELEASE, 8'h0, dev, 1'b0, 16'h0);
      n = n + CNTW'(1);
      if (spill != '0) begin
        dev   = 1'b1;
        seg   = spill;
        spill = '0;
        up    = 1'b0;
        for (int k = 0; k < HDR_LEN; k++) begin
          if (k <= ADDRESS_BYTES || reading) begin
            res_o[n[IDXW-1:0]] = hdr_rec(reading, k, '0, dev);
            n = n + CNTW'(1);
          end
        end
        ph = reading ? PH_DUMMY : PH_WRITE;
      end else begin
        ph = PH_IDLE;
      end
    end

    phase_nxt = ph;
    dev_nxt   = dev;
    seg_nxt   = seg;
    spill_nxt = spill;
    upper_nxt = up;
    low_nxt   = low;
    res_cnt_o = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      dev_r   <= 1'b0;
      seg_r   <= '0;
      spill_r <= '0;
      upper_r <= 1'b0;
      low_r   <= 8'h0;
    end else if (load_i) begin
      phase_r <= phase_nxt;
      dev_r   <= dev_nxt;
      seg_r   <= seg_nxt;
      spill_r <= spill_nxt;
      upper_r <= upper_nxt;
      low_r   <= low_nxt;
    end
  end

  `DSSBS_ASSERT_NOW(a_active_has_words, clk, rst_n, phase_r != PH_IDLE, seg_r != '0,
    "active burst with no words left")
  `DSSBS_ASSERT_NOW(a_spill_from_dev0, clk, rst_n, spill_r != '0 && phase_r != PH_IDLE,
    dev_r == 1'b0, "spill pending outside a device 0 burst")
  `DSSBS_ASSERT_NOW(a_upper_only_reading, clk, rst_n, upper_r && phase_r != PH_IDLE,
    phase_r == PH_READ, "upper byte pending outside read data phase")

endmodule

// ===== hdl/dual_spi_sram_burst_sequencer.sv =====
// Top level of the dual serial SRAM burst sequencer: ports, config and result queue.
//
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_tvalid/tready   | tdata fields, tuser = req_type
// out_    | output    | out_tvalid/tready  | tdata fields, tuser = kind, tlast = last
// cfg_    | input     | APB, pready high   | wrap_enable at byte address 0
//
// Each transaction is registered, then expanded combinationally into 1 to ADDRESS_BYTES+4
// results; the result queue drains one result per cycle while out_tready is high. A
// write word gives 2 results and a read byte inside a segment 1 or 2, more where a
// segment ends or a start releases a burst.
// The next transaction is taken while the final result of the current one goes out.
// Synchronous active-low reset clears the queue, the burst state and sets wrap_enable.
// A stalled output holds the queue and, once the input register is full, the input.
`timescale 1ns / 1ps
module dual_spi_sram_burst_sequencer
  import dssbs_pkg::*;
#(
  parameter int DEVICE_WORDS  = DEF_DEVICE_WORDS,
  parameter int ADDRESS_BYTES = DEF_ADDRESS_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // word_addr[17:0], word_count[35:18], write_word[51:36], rx_byte[59:52], zero pad
  input  logic [63:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tx_byte[7:0], device_select[8], read_clock_mode[9], read_word[25:10], zero pad
  output logic [31:0] out_tdata,
  // kind[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  `include "dual_spi_sram_burst_sequencer_assert.svh"

  localparam int MAXR = ADDRESS_BYTES + 4;
  localparam int CNTW = $clog2(MAXR + 1);
  localparam logic REG_WRAP_ENABLE = 1'b0;

  logic                   wrap_r, wrap_nxt;
  logic                   in_valid_r, in_valid_nxt;
  item_t                  item_r;
  result_t [MAXR-1:0]     buf_r, buf_nxt;
  logic [CNTW-1:0]        cnt_r, cnt_nxt;
  result_t [MAXR-1:0]     res;
  logic [CNTW-1:0]        res_cnt;
  logic                   q_free;
  logic                   load;
  logic                   pop;
  logic                   cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign wrap_nxt   = (cfg_wr && cfg_paddr[2] == REG_WRAP_ENABLE) ? cfg_pwdata[0] : wrap_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_WRAP_ENABLE) ? {31'b0, wrap_r} : 32'h0;

  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid & out_tready;
  assign q_free     = (cnt_r == '0) || (cnt_r == CNTW'(1) && out_tready);
  assign load       = in_valid_r & q_free;
  assign in_tready  = !in_valid_r || load;
  assign in_valid_nxt = in_tready ? in_tvalid : in_valid_r;

  assign out_tdata = {6'b0, buf_r[0].read_word, buf_r[0].read_clock_mode,
                      buf_r[0].device_select, buf_r[0].tx_byte};
  assign out_tuser = buf_r[0].kind;
  assign out_tlast = (cnt_r == CNTW'(1));

  dssbs_core #(
    .DEVICE_WORDS  (DEVICE_WORDS),
    .ADDRESS_BYTES (ADDRESS_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (load),
    .wrap_en_i (wrap_r),
    .item_i    (item_r),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (load) begin
      buf_nxt = res;
      cnt_nxt = res_cnt;
    end else if (pop) begin
      for (int i = 0; i < MAXR - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      buf_nxt[MAXR-1] = '0;
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r     <= 1'b1;
      in_valid_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      wrap_r     <= wrap_nxt;
      in_valid_r <= in_valid_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (in_tvalid && in_tready) begin
      item_r.req_type   <= req_t'(in_tuser);
      item_r.word_addr  <= in_tdata[17:0];
      item_r.word_count <= in_tdata[35:18];
      item_r.write_word <= in_tdata[51:36];
      item_r.rx_byte    <= in_tdata[59:52];
    end
  end

  `DSSBS_ASSERT_NOW(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CNTW'(MAXR),
    "result queue count out of range")
  `DSSBS_ASSERT_NOW(a_load_nonempty, clk, rst_n, load, res_cnt != '0,
    "transaction produced no result")
  `DSSBS_ASSERT_NEXT(a_load_count, clk, rst_n, load, cnt_r == $past(res_cnt),
    "result queue not loaded with the new count")

endmodule
